### rtl/core/iasa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the interval alias slot assigner.
// No dependencies; imported by the controller, the datapath and the top level.
package iasa_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned PASS_FIELD_W = 8;
  localparam int unsigned SIZE_W       = 40;
  localparam int unsigned SLOT_FIELD_W = 5;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned IN_TDATA_W   = 56;  // first, last, size
  localparam int unsigned OUT_TDATA_W  = 48;  // slot, opened, size, zero pad

  // Size used when the host sends zero
  localparam logic [SIZE_W-1:0] FALLBACK_BYTES = SIZE_W'(64 * 1024);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;        // capture the input transfer
    logic srch;       // search the table, start size read
    logic asgn;       // commit assignment and load result
    logic fin_rd;     // start size read for the report slot
    logic fin_out;    // load one report result
    logic empty_out;  // load the empty report
  } iasa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_fin;     // current input transfer is a finish item
    logic no_slots;   // table is empty
    logic fin_last;   // report slot is the highest open slot
    logic out_free;   // output register may be loaded this cycle
  } iasa_sts_t;

endpackage

### rtl/core/interval_alias_slot_assigner_top.sv
`timescale 1ns / 1ps
// Top level of the interval alias slot assigner: joins the sequencer and the
// datapath. Depends on iasa_pkg, iasa_ctrl and iasa_dp.
//
// Usage
//   Input channel (in_*): one transfer per interval, sorted by first pass.
//     in_tuser = 0 assigns the interval to the lowest slot whose last pass is
//     strictly before the interval's first pass, or opens a new slot if one is free.
//     in_tuser = 1 is a finish item: it reports every open slot's size in slot
//     order, tlast on the final report, then empties the table.
//   Output channel (out_*): result transfers; out_tuser gives the kind
//     (assignment, size report, table full, empty report).
//   Sequence: an interval is captured, then searched in parallel with the size
//     read (S_SRCH), then updated (S_UPD), which loads its result once the
//     output register is free. A finish item reads and reports one open slot
//     at a time (S_FRD, S_FOUT), set by the single read port of the size
//     memory; an empty table gives one empty report (S_FEMPTY). One item is in
//     flight at a time; in_tready returns the cycle after the item's last result
//     is loaded into the output register.
//   Reset: rst_n low empties the table and drops any pending result. No
//     clearing pass is needed; slot entries are only read once written.
//   Stall: a held-off result stays in the output register; the next input
//     transfer is still taken and worked up to the point of loading its result.
module interval_alias_slot_assigner_top
  import iasa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 32,
  parameter int unsigned PASS_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // first_pass[7:0], last_pass[15:8], size_bytes[55:16]
  input  logic                   in_tuser,   // mode[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot_index[4:0], opened_new[5],
                                             // slot_size[45:6], zero[47:46]
  output logic [KIND_W-1:0]      out_tuser,  // kind[1:0]
  output logic                   out_tlast
);

  iasa_cmd_t cmd;
  iasa_sts_t sts;

  // Sequencer: one item at a time, commands to the datapath
  iasa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot table, size memory, search and output register
  iasa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .PASS_BITS  (PASS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/core/iasa_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the interval alias slot assigner: walks each item through
// search, update and report steps. Depends on iasa_pkg.
module iasa_ctrl
  import iasa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  iasa_sts_t sts,
  output iasa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_UPD,
    S_FRD,
    S_FOUT,
    S_FEMPTY
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          if (!sts.in_fin) begin
            state_nxt = S_SRCH;
          end else if (sts.no_slots) begin
            state_nxt = S_FEMPTY;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_SRCH: begin
        cmd.srch  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.asgn  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = S_FOUT;
      end
      S_FOUT: begin
        if (sts.out_free) begin
          cmd.fin_out = 1'b1;
          state_nxt   = sts.fin_last ? S_IDLE : S_FRD;
        end
      end
      S_FEMPTY: begin
        if (sts.out_free) begin
          cmd.empty_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.srch, cmd.asgn, cmd.fin_rd, cmd.fin_out, cmd.empty_out}))
    else $error("iasa_ctrl: more than one command issued");

endmodule

### rtl/core/iasa_dp.sv
`timescale 1ns / 1ps
// Datapath of the interval alias slot assigner: slot table, size memory,
// search logic and the output register. Depends on iasa_pkg.
module iasa_dp
  import iasa_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 32,
  parameter int unsigned PASS_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  iasa_cmd_t              cmd,
  output iasa_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  // Slot table: end passes in flops (compared in parallel), sizes in memory
  logic [PASS_BITS-1:0]  end_pass_r [SLOT_COUNT];
  logic [SIZE_W-1:0]     size_mem   [SLOT_COUNT];
  logic [CNT_W-1:0]      open_r;

  // Captured interval
  logic [PASS_BITS-1:0]  first_r;
  logic [PASS_BITS-1:0]  lastp_r;
  logic [SIZE_W-1:0]     size_r;
  logic [SIZE_W-1:0]     size_in;

  // Search results
  logic [SLOT_COUNT-1:0] hit;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic                  found_r;
  logic [IDX_W-1:0]      pick_r;
  logic [SLOT_COUNT-1:0] gt_r;

  // Size memory port
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [SIZE_W-1:0]     rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_W-1:0]     wr_data;

  // Report walk
  logic [IDX_W-1:0]      fin_idx_r;
  logic                  full;

  // Output register
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic                  out_last_r;
  logic                  load;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic                  res_opened;
  logic [SIZE_W-1:0]     res_size;
  logic [KIND_W-1:0]     res_kind;
  logic                  res_last;
  logic [SIZE_W-1:0]     upd_size;
  logic [IDX_W+SLOT_FIELD_W-1:0] pick_ext;
  logic [CNT_W+SLOT_FIELD_W-1:0] open_ext;
  logic [IDX_W+SLOT_FIELD_W-1:0] fin_ext;

  assign size_in = (in_tdata[55:16] == '0) ? FALLBACK_BYTES : in_tdata[55:16];
  assign full    = (open_r == CNT_W'(SLOT_COUNT));

  assign sts.in_fin   = in_tuser;
  assign sts.no_slots = (open_r == '0);
  assign sts.fin_last = ((CNT_W'(fin_idx_r) + CNT_W'(1)) == open_r);
  assign sts.out_free = !out_valid_r || out_tready;

  // Parallel compare, lowest open slot wins
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i] = (CNT_W'(i) < open_r) && (end_pass_r[i] < first_r);
    end
    found = |hit;
    pick  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        pick = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      first_r <= PASS_BITS'(in_tdata[7:0]);
      lastp_r <= PASS_BITS'(in_tdata[15:8]);
      size_r  <= size_in;
    end
    if (cmd.srch) begin
      found_r <= found;
      pick_r  <= pick;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        gt_r[i] <= (lastp_r > end_pass_r[i]);
      end
    end
  end

  // Size memory: one read, one write per cycle, registered read data
  assign rd_en   = cmd.srch || cmd.fin_rd;
  assign rd_addr = cmd.srch ? pick : fin_idx_r;
  assign upd_size = (size_r > rd_data_r) ? size_r : rd_data_r;
  assign mem_we  = cmd.asgn && (found_r || !full);
  assign wr_addr = found_r ? pick_r : open_r[IDX_W-1:0];
  assign wr_data = found_r ? upd_size : size_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= size_mem[rd_addr];
    end
  end

  // End pass table: raise on reuse, set on open
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (mem_we && (wr_addr == IDX_W'(i)) && (!found_r || gt_r[i])) begin
        end_pass_r[i] <= lastp_r;
      end
    end
  end

  // Open count and report index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= '0;
      fin_idx_r <= '0;
    end else begin
      if (cmd.cap) begin
        fin_idx_r <= '0;
      end else if (cmd.fin_out) begin
        fin_idx_r <= fin_idx_r + IDX_W'(1);
      end
      if (cmd.asgn && !found_r && !full) begin
        open_r <= open_r + CNT_W'(1);
      end else if (cmd.fin_out && sts.fin_last) begin
        open_r <= '0;
      end
    end
  end

  // Result selection
  assign pick_ext = (IDX_W + SLOT_FIELD_W)'(pick_r);
  assign open_ext = (CNT_W + SLOT_FIELD_W)'(open_r);
  assign fin_ext  = (IDX_W + SLOT_FIELD_W)'(fin_idx_r);
  assign load     = cmd.asgn || cmd.fin_out || cmd.empty_out;

  always_comb begin
    res_kind   = KIND_EMPTY;
    res_slot   = '0;
    res_opened = 1'b0;
    res_size   = '0;
    res_last   = 1'b1;
    if (cmd.asgn) begin
      if (found_r) begin
        res_kind = KIND_ASSIGN;
        res_slot = pick_ext[SLOT_FIELD_W-1:0];
        res_size = upd_size;
      end else if (full) begin
        res_kind = KIND_FULL;
      end else begin
        res_kind   = KIND_ASSIGN;
        res_slot   = open_ext[SLOT_FIELD_W-1:0];
        res_opened = 1'b1;
        res_size   = size_r;
      end
    end else if (cmd.fin_out) begin
      res_kind = KIND_REPORT;
      res_slot = fin_ext[SLOT_FIELD_W-1:0];
      res_size = rd_data_r;
      res_last = sts.fin_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {2'b00, res_size, res_opened, res_slot};
      out_kind_r <= res_kind;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= CNT_W'(SLOT_COUNT))
    else $error("iasa_dp: open slot count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_tready))
    else $error("iasa_dp: pending result overwritten");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_out && sts.fin_last) |=> (open_r == '0))
    else $error("iasa_dp: table not cleared after final report");

endmodule
